>>> hw/rtl/cbu_pkg.sv
// Shared types and constants for the Cyrillic byte to UTF-8 transcoder.
package cbu_pkg;

  // Code page register values
  localparam logic [1:0] PAGE_KOI8R    = 2'd0;
  localparam logic [1:0] PAGE_CP1251   = 2'd1;
  localparam logic [1:0] PAGE_ISO88595 = 2'd2;

  // UTF-8 lead bytes for the Cyrillic block
  localparam logic [7:0] LEAD_LO = 8'hD0;
  localparam logic [7:0] LEAD_HI = 8'hD1;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_ONE = 1'b0,
    KIND_TWO = 1'b1
  } kind_t;

  // One classified request: one or two UTF-8 bytes to send
  typedef struct packed {
    kind_t      kind;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/cbu_front.sv
// Front end: code page register, byte classification, queue write.
module cbu_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [7:0]             in_byte,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,
  input  cbu_pkg::queue_status_t status,
  output logic                   q_wr,
  output cbu_pkg::entry_t        q_data
);
  import cbu_pkg::*;

  // KOI8-R lowercase 0xC0-0xDF: {lead is D1, second byte}
  function automatic logic [8:0] koi_lower(input logic [4:0] idx);
    logic [8:0] r;
    unique case (idx)
      5'd0:  r = {1'b1, 8'h8E};
      5'd1:  r = {1'b0, 8'hB0};
      5'd2:  r = {1'b0, 8'hB1};
      5'd3:  r = {1'b1, 8'h86};
      5'd4:  r = {1'b0, 8'hB4};
      5'd5:  r = {1'b0, 8'hB5};
      5'd6:  r = {1'b1, 8'h84};
      5'd7:  r = {1'b0, 8'hB3};
      5'd8:  r = {1'b1, 8'h85};
      5'd9:  r = {1'b0, 8'hB8};
      5'd10: r = {1'b0, 8'hB9};
      5'd11: r = {1'b0, 8'hBA};
      5'd12: r = {1'b0, 8'hBB};
      5'd13: r = {1'b0, 8'hBC};
      5'd14: r = {1'b0, 8'hBD};
      5'd15: r = {1'b0, 8'hBE};
      5'd16: r = {1'b0, 8'hBF};
      5'd17: r = {1'b1, 8'h8F};
      5'd18: r = {1'b1, 8'h80};
      5'd19: r = {1'b1, 8'h81};
      5'd20: r = {1'b1, 8'h82};
      5'd21: r = {1'b1, 8'h83};
      5'd22: r = {1'b0, 8'hB6};
      5'd23: r = {1'b0, 8'hB2};
      5'd24: r = {1'b1, 8'h8C};
      5'd25: r = {1'b1, 8'h8B};
      5'd26: r = {1'b0, 8'hB7};
      5'd27: r = {1'b1, 8'h88};
      5'd28: r = {1'b1, 8'h8D};
      5'd29: r = {1'b1, 8'h89};
      5'd30: r = {1'b1, 8'h87};
      default: r = {1'b1, 8'h8A};
    endcase
    return r;
  endfunction

  logic [1:0] code_page;
  logic       has_result;
  logic [8:0] koi;
  entry_t     cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_page <= PAGE_KOI8R;
    end else if (cfg_we) begin
      code_page <= cfg_wdata;
    end
  end

  always_comb begin
    koi        = koi_lower(in_byte[4:0]);
    has_result = 1'b0;
    cls.kind   = KIND_ONE;
    cls.first  = in_byte;
    cls.second = 8'h00;
    unique case (code_page)
      PAGE_KOI8R: begin
        if (!in_byte[7]) begin
          has_result = 1'b1;
        end else if (in_byte[7:6] == 2'b11) begin
          has_result = 1'b1;
          cls.kind   = KIND_TWO;
          if (!in_byte[5]) begin
            cls.first  = koi[8] ? LEAD_HI : LEAD_LO;
            cls.second = koi[7:0];
          end else begin
            // uppercase: always D0, second byte shifted by 0x20
            cls.first  = LEAD_LO;
            cls.second = koi[8] ? koi[7:0] + 8'd32 : koi[7:0] - 8'd32;
          end
        end
      end
      PAGE_CP1251: begin
        cls.kind = KIND_TWO;
        has_result = 1'b1;
        if (in_byte < 8'd160) begin
          cls.kind = KIND_ONE;
        end else if (in_byte >= 8'd192 && in_byte <= 8'd239) begin
          cls.first  = LEAD_LO;
          cls.second = in_byte - 8'd48;
        end else if (in_byte >= 8'd240) begin
          cls.first  = LEAD_HI;
          cls.second = in_byte - 8'd112;
        end else if (in_byte == 8'd168) begin
          cls.first  = LEAD_LO;
          cls.second = 8'd129;
        end else if (in_byte == 8'd184) begin
          cls.first  = LEAD_HI;
          cls.second = 8'd145;
        end else begin
          has_result = 1'b0;
        end
      end
      PAGE_ISO88595: begin
        cls.kind = KIND_TWO;
        has_result = 1'b1;
        if (in_byte < 8'd160) begin
          cls.kind = KIND_ONE;
        end else if (in_byte >= 8'd176 && in_byte <= 8'd223) begin
          cls.first  = LEAD_LO;
          cls.second = in_byte - 8'd32;
        end else if (in_byte >= 8'd224 && in_byte <= 8'd239) begin
          cls.first  = LEAD_HI;
          cls.second = in_byte - 8'd96;
        end else if (in_byte == 8'd161) begin
          cls.first  = LEAD_LO;
          cls.second = 8'd129;
        end else if (in_byte == 8'd241) begin
          cls.first  = LEAD_HI;
          cls.second = 8'd145;
        end else begin
          has_result = 1'b0;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // requests with no output byte are accepted and dropped here
  assign q_wr   = push && !status.full && has_result;
  assign q_data = cls;

endmodule

>>> hw/rtl/cbu_fifo.sv
// Short queue of classified requests between front and back.
module cbu_fifo #(
  parameter int unsigned DEPTH = cbu_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  cbu_pkg::entry_t        wr_data,
  input  logic                   rd_en,
  output cbu_pkg::entry_t        rd_data,
  output cbu_pkg::queue_status_t status
);
  import cbu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = slots[rd_ptr];

  always_comb begin
    unique case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !wr_en || rd_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !rd_en)
    else $error("queue read while empty");
`endif

endmodule

>>> hw/rtl/cbu_back.sv
// Back end: splits queued requests into single UTF-8 bytes on the result port.
module cbu_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cbu_pkg::entry_t        q_data,
  input  cbu_pkg::queue_status_t status,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             out_byte,
  output logic                   last_of_char
);
  import cbu_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       slot_free;

  assign slot_free = !hold_valid || pop;
  // the trailing byte of a pair goes out before the next request is taken
  assign q_rd      = slot_free && !pend_valid && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        hold_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_rd) begin
        hold_valid <= 1'b1;
        pend_valid <= (q_data.kind == KIND_TWO);
      end else begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        hold_byte <= pend_byte;
        hold_last <= 1'b1;
      end else if (q_rd) begin
        hold_byte <= q_data.first;
        hold_last <= (q_data.kind == KIND_ONE);
        pend_byte <= q_data.second;
      end
    end
  end

  assign empty        = !hold_valid;
  assign out_byte     = hold_byte;
  assign last_of_char = hold_last;

`ifndef ASSERT_OFF
  a_pend_has_lead: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> hold_valid && !hold_last)
    else $error("pending trailing byte without its lead byte shown");
  a_lead_has_pend: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_last |-> pend_valid)
    else $error("lead byte shown with no trailing byte pending");
  a_trail_follows: assert property (@(posedge clk) disable iff (rst)
    pend_valid && pop |=> hold_valid && hold_last)
    else $error("trailing byte did not follow its lead byte");
`endif

endmodule

>>> hw/rtl/cyrillic_byte_to_utf8_top.sv
// Top level of the Cyrillic single-byte to UTF-8 transcoder.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  request  | push / full         | in_byte[7:0]
//  result   | empty / pop         | out_byte[7:0], last_of_char
//  config   | cfg_we              | cfg_wdata[1:0] (source code page)
//
// One result byte can leave per cycle while pop is asserted. A two-byte
// request occupies the result port for both bytes, a single-byte request
// for one, a request with no mapping not at all; the next request is taken
// only once the trailing byte has entered the one-byte result register. An
// accepted request passes through the queue into the result register.
// Reset (rst, synchronous) empties the queue and the result register and
// selects KOI8-R. full follows only the queue, so requests keep arriving
// while a result waits for pop, until the queue fills.
module cyrillic_byte_to_utf8_top #(
  parameter int unsigned QUEUE_DEPTH = cbu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_char,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import cbu_pkg::*;

  queue_status_t q_status;
  entry_t        q_wr_data;
  entry_t        q_rd_data;
  logic          q_wr;
  logic          q_rd;

  // classify each request and queue only those that produce bytes
  cbu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (q_status),
    .q_wr      (q_wr),
    .q_data    (q_wr_data)
  );

  // decouples classification from byte emission
  cbu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // one UTF-8 byte per cycle while pop is asserted, out of a registered result slot
  cbu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rd_data),
    .status       (q_status),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last_of_char (last_of_char)
  );

  assign full = q_status.full;

endmodule
